@@ hw/rtl/selms_pkg.sv @@
// ----------------------------------------------------------------------------
// selms_pkg
// Shared widths, constants and state codes for the sign-error LMS filter.
// ----------------------------------------------------------------------------
package selms_pkg;

  localparam int TAPS_DEF   = 32;
  localparam int SAMPLE_W   = 16;
  localparam int WEIGHT_W   = 24;
  localparam int STEP_W     = 16;
  localparam int FRAC_SHIFT = 20;
  localparam int UPD_SHIFT  = 11;

  localparam logic [STEP_W-1:0] STEP_RESET = 16'd16;

  localparam logic signed [WEIGHT_W-1:0] WEIGHT_MAX = 24'sh7FFFFF;
  localparam logic signed [WEIGHT_W-1:0] WEIGHT_MIN = 24'sh800000;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_MAC   = 5'b00100,
    ST_ERR   = 5'b01000,
    ST_UPD   = 5'b10000
  } state_t;

  typedef struct packed {
    logic valid;
    logic upd;
  } mul_ctl_t;

endpackage

@@ hw/rtl/selms_ram.sv @@
// ----------------------------------------------------------------------------
// selms_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module selms_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/selms_mul.sv @@
// ----------------------------------------------------------------------------
// selms_mul
// Shared registered signed multiplier: tap by coefficient for the dot
// product, tap by step size for the coefficient update.
// ----------------------------------------------------------------------------
module selms_mul #(
  parameter int A_W = 16,
  parameter int B_W = 25
) (
  input  logic                        clk,
  input  logic                        rst,
  input  selms_pkg::mul_ctl_t         ctl_in,
  input  logic signed [A_W-1:0]       a,
  input  logic signed [B_W-1:0]       b,
  output selms_pkg::mul_ctl_t         ctl_out,
  output logic signed [A_W+B_W-1:0]   p
);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    p <= (A_W+B_W)'(a) * (A_W+B_W)'(b);
  end

endmodule

@@ hw/rtl/sign_error_lms_filter_core.sv @@
// ----------------------------------------------------------------------------
// sign_error_lms_filter_core
// Sign-error LMS adaptive FIR filter with one shared multiplier.
//
//   channel   dir  handshake                 payload
//   input     in   in_valid / in_ready       sample_in, desired
//   output    out  out_valid / out_ready     error_out
//   config    in   step_size_we              step_size
//
// Between acceptance and the next acceptance the multiplier walks all taps
// for the dot product, then again for the coefficient update. The result is
// presented from the error stage, before the update pass begins. When the
// error is exactly zero the update pass is skipped.
// After reset a clearing pass over all taps zeroes both RAMs, in_ready low.
// A result waiting at the output stalls the next transaction at its error
// stage only.
// ----------------------------------------------------------------------------
module sign_error_lms_filter_core #(
  parameter int TAPS = selms_pkg::TAPS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [selms_pkg::SAMPLE_W-1:0] sample_in,
  input  logic signed [selms_pkg::SAMPLE_W-1:0] desired,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [selms_pkg::SAMPLE_W-1:0] error_out,
  input  logic                                  step_size_we,
  input  logic [selms_pkg::STEP_W-1:0]          step_size
);

  localparam int SW      = selms_pkg::SAMPLE_W;
  localparam int WW      = selms_pkg::WEIGHT_W;
  localparam int ADDR_W  = $clog2(TAPS);
  localparam int MB_W    = WW + 1;
  localparam int PROD_W  = SW + MB_W;
  localparam int ACC_W   = SW + WW + ADDR_W;
  localparam int ERR_W   = ACC_W + 1;
  localparam int DELTA_W = PROD_W - selms_pkg::UPD_SHIFT;
  localparam int WSUM_W  = DELTA_W + 1;
  localparam logic [ADDR_W-1:0] LAST = ADDR_W'(TAPS - 1);
  localparam logic signed [ERR_W-1:0] E_RND = ERR_W'(1) <<< (selms_pkg::FRAC_SHIFT - 1);
  localparam logic signed [ERR_W-1:0] E_MAX = ERR_W'(selms_pkg::SAMPLE_MAX);
  localparam logic signed [ERR_W-1:0] E_MIN = ERR_W'(selms_pkg::SAMPLE_MIN);
  localparam logic signed [PROD_W-1:0] P_RND = PROD_W'(1) <<< (selms_pkg::UPD_SHIFT - 1);
  localparam logic signed [WSUM_W-1:0] W_MAX = WSUM_W'(selms_pkg::WEIGHT_MAX);
  localparam logic signed [WSUM_W-1:0] W_MIN = WSUM_W'(selms_pkg::WEIGHT_MIN);

  selms_pkg::state_t state;

  logic [ADDR_W-1:0]           head;
  logic [ADDR_W-1:0]           idx;
  logic [ADDR_W-1:0]           tap_addr;
  logic [ADDR_W-1:0]           wa1;
  logic [ADDR_W-1:0]           wa2;
  logic                        issuing;
  logic                        rd_v;
  logic                        err_neg;
  logic [selms_pkg::STEP_W-1:0] step_reg;
  logic signed [SW-1:0]        d_reg;
  logic signed [ACC_W-1:0]     acc;
  logic signed [WW-1:0]        w_d;

  logic [ADDR_W-1:0]           head_inc;
  logic [ADDR_W-1:0]           tap_dec;
  logic                        tap_we;
  logic [ADDR_W-1:0]           tap_waddr;
  logic [SW-1:0]               tap_wdata;
  logic [SW-1:0]               tap_q;
  logic                        w_we;
  logic [ADDR_W-1:0]           w_waddr;
  logic [WW-1:0]               w_wdata;
  logic [WW-1:0]               w_q;

  selms_pkg::mul_ctl_t         mul_in;
  selms_pkg::mul_ctl_t         mul_out;
  logic signed [MB_W-1:0]      mul_b;
  logic signed [PROD_W-1:0]    prod;

  logic signed [ERR_W-1:0]     d_al;
  logic signed [ERR_W-1:0]     e35;
  logic signed [ERR_W-1:0]     e_rnd;
  logic signed [SW-1:0]        err_sat;
  logic signed [PROD_W-1:0]    p_rnd;
  logic signed [DELTA_W-1:0]   delta;
  logic signed [WSUM_W-1:0]    w_ext;
  logic signed [WSUM_W-1:0]    w_sum;
  logic signed [WW-1:0]        w_new;
  logic                        pipe_empty;
  logic                        err_go;

  assign in_ready   = (state == selms_pkg::ST_IDLE);
  assign head_inc   = (head == LAST) ? '0 : head + 1'b1;
  assign tap_dec    = (tap_addr == '0) ? LAST : tap_addr - 1'b1;
  assign pipe_empty = !issuing && !rd_v && !mul_out.valid;
  assign err_go     = (state == selms_pkg::ST_ERR) && (!out_valid || out_ready);

  // storage
  always_comb begin
    tap_we    = 1'b0;
    tap_waddr = head_inc;
    tap_wdata = sample_in;
    w_we      = 1'b0;
    w_waddr   = wa2;
    w_wdata   = w_new;
    case (state)
      selms_pkg::ST_CLEAR: begin
        tap_we    = 1'b1;
        tap_waddr = idx;
        tap_wdata = '0;
        w_we      = 1'b1;
        w_waddr   = idx;
        w_wdata   = '0;
      end
      selms_pkg::ST_IDLE: begin
        tap_we = in_valid;
      end
      selms_pkg::ST_UPD: begin
        w_we = mul_out.valid;
      end
      default: begin
        tap_we = 1'b0;
      end
    endcase
  end

  selms_ram #(.WIDTH(SW), .DEPTH(TAPS)) u_tap_ram (
    .clk   (clk),
    .we    (tap_we),
    .waddr (tap_waddr),
    .wdata (tap_wdata),
    .raddr (tap_addr),
    .rdata (tap_q)
  );

  selms_ram #(.WIDTH(WW), .DEPTH(TAPS)) u_weight_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (w_wdata),
    .raddr (idx),
    .rdata (w_q)
  );

  // shared multiplier
  assign mul_in.valid = rd_v;
  assign mul_in.upd   = (state == selms_pkg::ST_UPD);
  assign mul_b = mul_in.upd ? $signed({{(MB_W - selms_pkg::STEP_W){1'b0}}, step_reg})
                            : $signed({w_q[WW-1], w_q});

  selms_mul #(.A_W(SW), .B_W(MB_W)) u_mul (
    .clk     (clk),
    .rst     (rst),
    .ctl_in  (mul_in),
    .a       ($signed(tap_q)),
    .b       (mul_b),
    .ctl_out (mul_out),
    .p       (prod)
  );

  // error rounding and saturation
  always_comb begin
    d_al  = ERR_W'(d_reg) <<< selms_pkg::FRAC_SHIFT;
    e35   = d_al - ERR_W'(acc);
    e_rnd = (e35 + E_RND) >>> selms_pkg::FRAC_SHIFT;
    if (e_rnd > E_MAX) begin
      err_sat = selms_pkg::SAMPLE_MAX;
    end else if (e_rnd < E_MIN) begin
      err_sat = selms_pkg::SAMPLE_MIN;
    end else begin
      err_sat = e_rnd[SW-1:0];
    end
  end

  // coefficient update
  always_comb begin
    p_rnd = prod + P_RND;
    delta = $signed(p_rnd[PROD_W-1:selms_pkg::UPD_SHIFT]);
    w_ext = WSUM_W'(w_d);
    w_sum = err_neg ? w_ext - WSUM_W'(delta) : w_ext + WSUM_W'(delta);
    if (w_sum > W_MAX) begin
      w_new = selms_pkg::WEIGHT_MAX;
    end else if (w_sum < W_MIN) begin
      w_new = selms_pkg::WEIGHT_MIN;
    end else begin
      w_new = w_sum[WW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    wa1 <= idx;
    wa2 <= wa1;
    w_d <= $signed(w_q);
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= selms_pkg::ST_CLEAR;
      head      <= '0;
      idx       <= '0;
      tap_addr  <= '0;
      issuing   <= 1'b0;
      rd_v      <= 1'b0;
      out_valid <= 1'b0;
      err_neg   <= 1'b0;
      step_reg  <= selms_pkg::STEP_RESET;
    end else begin
      if (step_size_we) begin
        step_reg <= step_size;
      end
      if (err_go) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      rd_v <= issuing;
      case (state)
        selms_pkg::ST_CLEAR: begin
          if (idx == LAST) begin
            idx   <= '0;
            state <= selms_pkg::ST_IDLE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        selms_pkg::ST_IDLE: begin
          if (in_valid) begin
            head     <= head_inc;
            tap_addr <= head_inc;
            idx      <= '0;
            issuing  <= 1'b1;
            acc      <= '0;
            d_reg    <= desired;
            state    <= selms_pkg::ST_MAC;
          end
        end
        selms_pkg::ST_MAC: begin
          if (issuing) begin
            idx      <= idx + 1'b1;
            tap_addr <= tap_dec;
            if (idx == LAST) begin
              issuing <= 1'b0;
            end
          end
          if (mul_out.valid) begin
            acc <= acc + ACC_W'(prod);
          end
          if (pipe_empty) begin
            state <= selms_pkg::ST_ERR;
          end
        end
        selms_pkg::ST_ERR: begin
          if (err_go) begin
            error_out <= err_sat;
            if (e35 == '0) begin
              state <= selms_pkg::ST_IDLE;
            end else begin
              err_neg  <= e35[ERR_W-1];
              idx      <= '0;
              tap_addr <= head;
              issuing  <= 1'b1;
              state    <= selms_pkg::ST_UPD;
            end
          end
        end
        selms_pkg::ST_UPD: begin
          if (issuing) begin
            idx      <= idx + 1'b1;
            tap_addr <= tap_dec;
            if (idx == LAST) begin
              issuing <= 1'b0;
            end
          end
          if (pipe_empty) begin
            state <= selms_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= selms_pkg::ST_CLEAR;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted transaction did not make the block busy");

  a_weight_write_upd: assert property (@(posedge clk) disable iff (rst)
    w_we |-> (state == selms_pkg::ST_UPD) || (state == selms_pkg::ST_CLEAR))
    else $error("coefficient write outside update or clearing");

  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (rst)
    (state == selms_pkg::ST_IDLE) |-> !issuing && !rd_v && !mul_out.valid)
    else $error("multiplier pipeline busy while idle");

  a_mul_mode: assert property (@(posedge clk) disable iff (rst)
    mul_out.valid && mul_out.upd |-> (state == selms_pkg::ST_UPD))
    else $error("update product arrived outside update pass");
`endif

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for sign_error_lms_filter_core. A fixed table of edge
// cases runs first, then a short impulse drive at full step size that makes
// large coefficient moves, then random phases at several step sizes, where
// full step size walks coefficients into saturation. Error values come from
// a bit-accurate software copy of the filter, or from the edge table.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int TAPS         = selms_pkg::TAPS_DEF;
  localparam int SW           = selms_pkg::SAMPLE_W;
  localparam int WW           = selms_pkg::WEIGHT_W;
  localparam int STW          = selms_pkg::STEP_W;
  localparam int FRAC         = selms_pkg::FRAC_SHIFT;
  localparam int USH          = selms_pkg::UPD_SHIFT;
  localparam int UPD_WAIT     = 2*TAPS + 16;
  localparam int IDLE_LIMIT   = 4000;
  localparam int DRIVE_ROUNDS = 8;
  localparam int PHASE_ITEMS  = 215;
  localparam int PHASES       = 6;
  localparam int DIR_ROWS     = 20;

  localparam logic signed [SW-1:0] S_MAX     = selms_pkg::SAMPLE_MAX;
  localparam logic signed [SW-1:0] S_MIN     = selms_pkg::SAMPLE_MIN;
  localparam logic signed [SW-1:0] DRIVE_AMP = 16'sd4095;
  localparam logic signed [SW-1:0] ZERO      = 16'sd0;
  localparam longint W_MAX = longint'(selms_pkg::WEIGHT_MAX);
  localparam longint W_MIN = longint'(selms_pkg::WEIGHT_MIN);

  typedef struct packed {
    logic signed [SW-1:0] smp;
    logic signed [SW-1:0] dsr;
    logic                 known;
    logic signed [SW-1:0] err;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [SW-1:0] sample_in = '0;
  logic signed [SW-1:0] desired = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [SW-1:0] error_out;
  logic step_size_we = 1'b0;
  logic [STW-1:0] step_size = '0;

  // software copy of the filter state
  logic signed [SW-1:0] tap_mem [TAPS];
  logic signed [WW-1:0] coef_mem [TAPS];
  logic [STW-1:0] mu;

  logic signed [SW-1:0] errors_due [$];
  logic signed [SW-1:0] head_err;
  int fail_cnt = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  logic [31:0] rx_bits = '0;
  int rx_left = 0;

  // edge cases, expected error typed in where it is obvious
  dir_row_t dir_tab [DIR_ROWS] = '{
    '{ZERO,         ZERO,         1'b1, ZERO},
    '{ZERO,         S_MIN,        1'b1, S_MIN},
    '{ZERO,         S_MAX,        1'b1, S_MAX},
    '{16'sd128,     16'sd1,       1'b1, 16'sd1},
    '{16'sd1,       ZERO,         1'b1, ZERO},
    '{ZERO,         ZERO,         1'b0, ZERO},
    '{S_MAX,        S_MAX,        1'b0, ZERO},
    '{S_MAX,        S_MIN,        1'b0, ZERO},
    '{S_MIN,        S_MAX,        1'b0, ZERO},
    '{S_MIN,        S_MIN,        1'b0, ZERO},
    '{-16'sd1,      -16'sd1,      1'b0, ZERO},
    '{16'sd1,       16'sd1,       1'b0, ZERO},
    '{16'sh5555,    16'shAAAA,    1'b0, ZERO},
    '{16'shAAAA,    16'sh5555,    1'b0, ZERO},
    '{S_MAX,        ZERO,         1'b0, ZERO},
    '{ZERO,         S_MIN,        1'b0, ZERO},
    '{S_MIN,        ZERO,         1'b0, ZERO},
    '{16'sh00FF,    16'shFF00,    1'b0, ZERO},
    '{16'shFF00,    16'sh00FF,    1'b0, ZERO},
    '{ZERO,         ZERO,         1'b0, ZERO}
  };

  sign_error_lms_filter_core #(
    .TAPS(TAPS)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .sample_in   (sample_in),
    .desired     (desired),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .error_out   (error_out),
    .step_size_we(step_size_we),
    .step_size   (step_size)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shift in one sample, filter, adapt, and return the rounded error
  function automatic logic signed [SW-1:0] lms_step(
    input logic signed [SW-1:0] x,
    input logic signed [SW-1:0] d
  );
    longint acc;
    longint e35;
    longint e;
    longint delta;
    longint w;
    acc = 0;
    for (int i = TAPS - 1; i > 0; i--) tap_mem[i] = tap_mem[i-1];
    tap_mem[0] = x;
    for (int i = 0; i < TAPS; i++) acc += longint'(tap_mem[i]) * longint'(coef_mem[i]);
    e35 = (longint'(d) <<< FRAC) - acc;
    e = (e35 + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
    if (e > longint'(S_MAX)) e = longint'(S_MAX);
    if (e < longint'(S_MIN)) e = longint'(S_MIN);
    if (e35 != 0) begin
      for (int i = 0; i < TAPS; i++) begin
        delta = (longint'(mu) * longint'(tap_mem[i]) + (longint'(1) <<< (USH - 1)))
                >>> USH;
        w = (e35 > 0) ? longint'(coef_mem[i]) + delta : longint'(coef_mem[i]) - delta;
        if (w > W_MAX) w = W_MAX;
        if (w < W_MIN) w = W_MIN;
        coef_mem[i] = w[WW-1:0];
      end
    end
    return e[SW-1:0];
  endfunction

  function automatic logic signed [SW-1:0] rand_sample();
    logic signed [SW-1:0] v;
    case ($urandom_range(0, 9))
      0: v = S_MAX;
      1: v = S_MIN;
      2, 3: v = SW'(int'($urandom_range(0, 511)) - 256);
      default: v = SW'($urandom);
    endcase
    return v;
  endfunction

  task automatic send_sample(
    input logic signed [SW-1:0] smp,
    input logic signed [SW-1:0] dsr,
    input logic                 known,
    input logic signed [SW-1:0] err
  );
    logic signed [SW-1:0] due;
    @(negedge clk);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, UPD_WAIT)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 8);
    end
    in_valid  <= 1'b1;
    sample_in <= smp;
    desired   <= dsr;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    due = lms_step(smp, dsr);
    errors_due.push_back(known ? err : due);
  endtask

  task automatic stop_input();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
  endtask

  // only while idle: wait out the update pass of the last transaction too
  task automatic set_step_size(input logic [STW-1:0] v);
    stop_input();
    while (errors_due.size() != 0) @(posedge clk);
    repeat (UPD_WAIT) @(posedge clk);
    @(negedge clk);
    step_size_we <= 1'b1;
    step_size    <= v;
    @(negedge clk);
    step_size_we <= 1'b0;
    mu = v;
  endtask

  always @(negedge clk) begin
    if (rx_left == 0) begin
      case ($urandom_range(0, 3))
        0: rx_bits = '1;
        1: rx_bits = $urandom;
        2: rx_bits = $urandom | $urandom;
        default: rx_bits = '0;
      endcase
      rx_left = 32;
    end
    out_ready <= rx_bits[0];
    rx_bits = rx_bits >> 1;
    rx_left--;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (errors_due.size() == 0) begin
        $error("error_out: unexpected transaction, expected none, got %0d", error_out);
        fail_cnt++;
      end else begin
        head_err = errors_due.pop_front();
        if (error_out !== head_err) begin
          $error("error_out: expected %0d, got %0d", head_err, error_out);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("** sign_error_lms_filter_core: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [STW-1:0] v;
    mu = selms_pkg::STEP_RESET;
    for (int i = 0; i < TAPS; i++) begin
      tap_mem[i]  = '0;
      coef_mem[i] = '0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) begin
      send_sample(dir_tab[i].smp, dir_tab[i].dsr, dir_tab[i].known, dir_tab[i].err);
    end

    // empty the delay line so the drive below sees a single impulse
    repeat (TAPS) send_sample(ZERO, rand_sample(), 1'b0, ZERO);

    // impulse drive: even coefficients move up, odd ones down
    set_step_size('1);
    for (int r = 0; r < DRIVE_ROUNDS * TAPS; r++) begin
      send_sample((r % TAPS == 0) ? DRIVE_AMP : ZERO,
                  (r % 2 == 0) ? S_MAX : S_MIN, 1'b0, ZERO);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: v = '1;
        1: v = '0;
        2: v = 16'd1;
        3: v = STW'($urandom_range(0, 2047));
        default: v = STW'($urandom);
      endcase
      set_step_size(v);
      repeat (PHASE_ITEMS) send_sample(rand_sample(), rand_sample(), 1'b0, ZERO);
    end

    stop_input();
    while (errors_due.size() != 0) @(posedge clk);
    repeat (UPD_WAIT) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("** sign_error_lms_filter_core: PASSED **");
    end else begin
      $display("** sign_error_lms_filter_core: FAILED **");
    end
    $finish;
  end

endmodule
